/* hw/rtl/tlvsim_pkg.sv */
`timescale 1ns / 1ps

package tlvsim_pkg;

  // Id table geometry.
  localparam int TBL_ENTRIES = 16;
  localparam int TBL_AW      = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;
  localparam int TBL_CNT_W   = $clog2(TBL_ENTRIES + 1);

  // Packet length limits.
  localparam logic [11:0] MAX_PACKET_BYTES = 12'd2048;
  localparam logic [11:0] POS_MAX          = 12'd4095;

  // Length byte decoding.
  localparam logic [7:0] LEN_EXT_FLAG = 8'h80;
  localparam logic [7:0] LEN_LOW_MASK = 8'h7f;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_STATUS_CODE = 2'd0,
    CFG_END_TAG     = 2'd1,
    CFG_STREAM_TAG  = 2'd2,
    CFG_ENTRY_COUNT = 2'd3
  } cfg_idx_e;

  // Result codes.
  typedef enum logic [1:0] {
    OUT_MATCH    = 2'd0,
    OUT_NO_MATCH = 2'd1,
    OUT_BAD_LEN  = 2'd2,
    OUT_NOT_STAT = 2'd3
  } outcome_e;

  // Option list parser phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TAG    = 3'd1,
    PH_LEN    = 3'd2,
    PH_LENEXT = 3'd3,
    PH_VALUE  = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  // Input item mode carried in tuser bit 0.
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_ENTRY  = 1'b1;

endpackage

/* hw/rtl/tlvsim_ram.sv */
`timescale 1ns / 1ps

module tlvsim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/tlv_stream_id_matcher.sv */
`timescale 1ns / 1ps

// Channel    Direction  Transfer when                  Carries
// s_axis     in         s_axis_tvalid & s_axis_tready  packet byte or id table entry write
// m_axis     out        m_axis_tvalid & m_axis_tready  outcome and found id, one per packet
// cfg        in         cfg_valid_i & cfg_ready_o      register index and write data
//
// An ordinary packet byte or a table write is taken without a stall. The last byte of a packet
// moves to an emit state that loads the output register, and waits there while the sink holds it.
// A byte that completes a stream id option starts a search of the id table memory, one entry
// read per cycle through its single read port, over at most min(entry_count, 16) entries; the
// input waits until the search ends, and a hit ends it early.
// Reset is asynchronous and active low; the table memory is not cleared and no pass is run.
// The input is accepted while a finished result still waits on the output.

module tlv_stream_id_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: data_byte[7:0], packet_length[19:8], entry_index[23:20], entry_id[55:24]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  // tuser: mode[0], first[1]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // tdata: outcome[1:0], found_id[33:2], zero[39:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tlvsim_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  // Input fields.
  logic               in_mode;
  logic               in_first;
  logic [7:0]         in_byte;
  logic [11:0]        in_plen;
  logic [3:0]         in_eidx;
  logic [31:0]        in_eid;

  assign in_mode  = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_byte  = s_axis_tdata[7:0];
  assign in_plen  = s_axis_tdata[19:8];
  assign in_eidx  = s_axis_tdata[23:20];
  assign in_eid   = s_axis_tdata[55:24];

  // Registers.
  state_e             state_q, state_d;
  logic [7:0]         stat_code_q, end_tag_q, stream_tag_q;
  logic [4:0]         entry_count_q;
  phase_e             phase_q, phase_d;
  logic [11:0]        pos_q, pos_d;
  logic [11:0]        total_q, total_d;
  logic [7:0]         opt_tag_q, opt_tag_d;
  logic [31:0]        opt_len_q, opt_len_d;
  logic [6:0]         len_left_q, len_left_d;
  logic [31:0]        acc_q, acc_d;
  outcome_e           outcome_q, outcome_d;
  logic [31:0]        matched_q, matched_d;
  logic [31:0]        key_q, key_d;
  logic [TBL_CNT_W-1:0] idx_q, idx_d;
  logic               cmp_valid_q, cmp_valid_d;
  logic               pend_last_q, pend_last_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_code_q;
  logic [31:0]        out_id_q;

  // Combinational helpers.
  logic               in_xfer;
  logic               out_free;
  logic               len_known;
  logic               start_search;
  logic               load_out;
  logic [33:0]        len_end;
  logic [TBL_CNT_W-1:0] n_entries;
  logic               ram_we, ram_re;
  logic [31:0]        ram_rdata;

  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign n_entries = (32'(entry_count_q) > TBL_ENTRIES) ? TBL_CNT_W'(TBL_ENTRIES)
                                                        : TBL_CNT_W'(entry_count_q);

  // Table writes come straight from input transfers in mode one.
  assign ram_we = in_xfer & (in_mode == MODE_ENTRY) & (32'(in_eidx) < TBL_ENTRIES);

  tlvsim_ram #(
    .WIDTH (32),
    .DEPTH (TBL_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (TBL_AW'(in_eidx)),
    .wdata_i (in_eid),
    .re_i    (ram_re),
    .raddr_i (idx_q[TBL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Parser, table search and result hand-off.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    pos_d        = pos_q;
    total_d      = total_q;
    opt_tag_d    = opt_tag_q;
    opt_len_d    = opt_len_q;
    len_left_d   = len_left_q;
    acc_d        = acc_q;
    outcome_d    = outcome_q;
    matched_d    = matched_q;
    key_d        = key_q;
    idx_d        = idx_q;
    cmp_valid_d  = cmp_valid_q;
    pend_last_d  = pend_last_q;
    len_known    = 1'b0;
    start_search = 1'b0;
    load_out     = 1'b0;
    ram_re       = 1'b0;
    len_end      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_mode == MODE_PACKET && (in_first || phase_q != PH_IDLE)) begin
          if (in_first) begin
            // A first byte always opens a fresh packet.
            pos_d      = '0;
            opt_tag_d  = '0;
            opt_len_d  = '0;
            len_left_d = '0;
            acc_d      = '0;
            matched_d  = '1;
            total_d    = (in_plen < MAX_PACKET_BYTES) ? in_plen : MAX_PACKET_BYTES;
            if (in_byte != stat_code_q) begin
              outcome_d = OUT_NOT_STAT;
              phase_d   = PH_DONE;
            end else begin
              outcome_d = OUT_NO_MATCH;
              phase_d   = PH_TAG;
            end
          end else if (pos_q >= total_q) begin
            // Bytes past the stated length end the scan.
            if (phase_q == PH_LEN || phase_q == PH_LENEXT) begin
              outcome_d = OUT_BAD_LEN;
            end
            if (phase_q != PH_DONE) begin
              phase_d = PH_DONE;
            end
          end else begin
            case (phase_q)
              PH_TAG: begin
                if (in_byte == end_tag_q) begin
                  phase_d = PH_DONE;
                end else begin
                  opt_tag_d = in_byte;
                  phase_d   = PH_LEN;
                end
              end
              PH_LEN: begin
                if ((in_byte & LEN_EXT_FLAG) != 8'h00) begin
                  len_left_d = 7'(in_byte & LEN_LOW_MASK);
                  opt_len_d  = '0;
                  if ((in_byte & LEN_LOW_MASK) == 8'h00) begin
                    len_known = 1'b1;
                  end else begin
                    phase_d = PH_LENEXT;
                  end
                end else begin
                  opt_len_d = {24'h0, in_byte};
                  len_known = 1'b1;
                end
              end
              PH_LENEXT: begin
                opt_len_d  = {opt_len_q[23:0], in_byte};
                len_left_d = len_left_q - 7'd1;
                if (len_left_q == 7'd1) begin
                  len_known = 1'b1;
                end
              end
              PH_VALUE: begin
                if (opt_tag_q == stream_tag_q) begin
                  acc_d = {acc_q[23:0], in_byte};
                end
                opt_len_d = opt_len_q - 32'd1;
                if (opt_len_q == 32'd1) begin
                  if (opt_tag_q == stream_tag_q) begin
                    start_search = 1'b1;
                    key_d        = {acc_q[23:0], in_byte};
                  end else begin
                    phase_d = PH_TAG;
                  end
                end
              end
              default: begin
              end
            endcase

            // The full option length is known: check it against the packet end.
            if (len_known) begin
              len_end = {22'h0, pos_q} + {2'b00, opt_len_d} + 34'd1;
              if (len_end >= {22'h0, total_q}) begin
                outcome_d = OUT_BAD_LEN;
                phase_d   = PH_DONE;
              end else begin
                acc_d = '0;
                if (opt_len_d == 32'd0) begin
                  if (opt_tag_q == stream_tag_q) begin
                    start_search = 1'b1;
                    key_d        = '0;
                  end else begin
                    phase_d = PH_TAG;
                  end
                end else begin
                  phase_d = PH_VALUE;
                end
              end
            end
          end

          if (pos_d < POS_MAX) begin
            pos_d = pos_d + 12'd1;
          end

          if (start_search) begin
            idx_d       = '0;
            cmp_valid_d = 1'b0;
            pend_last_d = s_axis_tlast;
            state_d     = ST_SEARCH;
          end else if (s_axis_tlast) begin
            // End of packet: close the scan before the result goes out.
            if (phase_d == PH_LEN || phase_d == PH_LENEXT) begin
              outcome_d = OUT_BAD_LEN;
            end
            phase_d = PH_DONE;
            state_d = ST_EMIT;
          end
        end
      end

      ST_SEARCH: begin
        // One entry read per cycle; the compare sees the previous read.
        if (cmp_valid_q && ram_rdata == key_q) begin
          outcome_d   = OUT_MATCH;
          matched_d   = key_q;
          phase_d     = PH_DONE;
          cmp_valid_d = 1'b0;
          state_d     = pend_last_q ? ST_EMIT : ST_IDLE;
        end else if (idx_q < n_entries) begin
          ram_re      = 1'b1;
          idx_d       = idx_q + TBL_CNT_W'(1);
          cmp_valid_d = 1'b1;
        end else begin
          phase_d     = pend_last_q ? PH_DONE : PH_TAG;
          cmp_valid_d = 1'b0;
          state_d     = pend_last_q ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Hand the result to the output register and clear the scan.
        if (out_free) begin
          load_out   = 1'b1;
          phase_d    = PH_IDLE;
          pos_d      = '0;
          total_d    = '0;
          opt_tag_d  = '0;
          opt_len_d  = '0;
          len_left_d = '0;
          acc_d      = '0;
          outcome_d  = OUT_NO_MATCH;
          matched_d  = '1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~m_axis_tready);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      stat_code_q   <= 8'd0;
      end_tag_q     <= 8'd0;
      stream_tag_q  <= 8'd18;
      entry_count_q <= 5'd0;
      phase_q       <= PH_IDLE;
      pos_q         <= '0;
      total_q       <= '0;
      opt_tag_q     <= '0;
      opt_len_q     <= '0;
      len_left_q    <= '0;
      acc_q         <= '0;
      outcome_q     <= OUT_NO_MATCH;
      matched_q     <= '1;
      idx_q         <= '0;
      cmp_valid_q   <= 1'b0;
      pend_last_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      opt_tag_q   <= opt_tag_d;
      opt_len_q   <= opt_len_d;
      len_left_q  <= len_left_d;
      acc_q       <= acc_d;
      outcome_q   <= outcome_d;
      matched_q   <= matched_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_STATUS_CODE: stat_code_q   <= cfg_data_i;
          CFG_END_TAG:     end_tag_q     <= cfg_data_i;
          CFG_STREAM_TAG:  stream_tag_q  <= cfg_data_i;
          CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load_out) begin
      out_code_q <= outcome_q;
      out_id_q   <= (outcome_q == OUT_MATCH) ? matched_q : 32'hffff_ffff;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'h00, out_id_q, out_code_q};

endmodule

/* hw/rtl/tlvsim_checker.sv */
`timescale 1ns / 1ps

module tlvsim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import tlvsim_pkg::*;

  // A result held by a stalled sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // Only a match carries an identifier; every other outcome reports all ones.
  a_id_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != OUT_MATCH |-> m_axis_tdata[33:2] == 32'hffff_ffff)
    else $error("found id set without a match");

  // A one-byte packet always goes busy to deliver its result.
  a_short_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tuser[1]
      && s_axis_tuser[0] == MODE_PACKET |=> !s_axis_tready)
    else $error("single byte packet did not stall the input");

  // A table write never stalls the input.
  a_entry_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == MODE_ENTRY |=> s_axis_tready)
    else $error("table write stalled the input");

endmodule

bind tlv_stream_id_matcher tlvsim_checker u_tlvsim_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tlvsim_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 3000;

  // One input transfer, field by field.
  typedef struct {
    logic        mode;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [11:0] pkt_len;
    logic [3:0]  entry_index;
    logic [31:0] entry_id;
  } stim_t;

  // One packet verdict as the block reports it.
  typedef struct {
    outcome_e    outcome;
    logic [31:0] found_id;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  tlv_stream_id_matcher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the configuration registers, updated at each accepted write.
  logic [7:0]  packet_code = 8'd0;
  logic [7:0]  end_tag     = 8'd0;
  logic [7:0]  sid_tag     = 8'd18;
  logic [4:0]  live_count  = 5'd0;

  // Mirror of the id table and of the option list scan.
  logic [31:0] stream_ids [TBL_ENTRIES];
  phase_e      rx_phase;
  logic [11:0] rx_pos;
  logic [11:0] rx_total;
  logic [7:0]  opt_tag;
  logic [31:0] opt_len;
  logic [6:0]  len_left;
  logic [31:0] id_acc;
  outcome_e    verdict;
  logic [31:0] hit_id;

  verdict_t    expected_verdicts [$];
  verdict_t    head_v;

  // Stimulus control shared by the test tasks.
  logic [7:0]  pkt_bytes [$];
  logic [11:0] pkt_len_field;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mix_pct = 0;
  int          err_cnt = 0;
  int          quiet = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_scan();
    rx_phase = PH_IDLE;
    rx_pos   = '0;
    rx_total = '0;
    opt_tag  = '0;
    opt_len  = '0;
    len_left = '0;
    id_acc   = '0;
    verdict  = OUT_NO_MATCH;
    hit_id   = '1;
  endfunction

  // Linear search over the live part of the table; the first hit ends the scan.
  function automatic void search_ids(input logic [31:0] id_val);
    int n;
    n = (live_count < TBL_ENTRIES) ? int'(live_count) : TBL_ENTRIES;
    for (int i = 0; i < n; i++) begin
      if (stream_ids[i] == id_val) begin
        verdict  = OUT_MATCH;
        hit_id   = id_val;
        rx_phase = PH_DONE;
        return;
      end
    end
    rx_phase = PH_TAG;
  endfunction

  // The scan stops; a stop inside the length bytes counts as a bad length.
  function automatic void close_option_list();
    if (rx_phase == PH_IDLE || rx_phase == PH_DONE) return;
    if (rx_phase == PH_LEN || rx_phase == PH_LENEXT) verdict = OUT_BAD_LEN;
    rx_phase = PH_DONE;
  endfunction

  // The option length is complete at the byte at rx_pos. A value that would
  // reach the packet end or go past it stops the scan.
  function automatic void finish_length();
    logic [33:0] reach;
    reach = rx_pos + opt_len + 34'd1;
    if (reach >= rx_total) begin
      verdict  = OUT_BAD_LEN;
      rx_phase = PH_DONE;
      return;
    end
    id_acc = '0;
    if (opt_len == 0) begin
      if (opt_tag == sid_tag) search_ids('0);
      else rx_phase = PH_TAG;
    end else begin
      rx_phase = PH_VALUE;
    end
  endfunction

  function automatic void advance_option_parser(input logic [7:0] b);
    case (rx_phase)
      PH_TAG: begin
        if (b == end_tag) begin
          rx_phase = PH_DONE;
        end else begin
          opt_tag  = b;
          rx_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if ((b & LEN_EXT_FLAG) != 0) begin
          len_left = 7'(b & LEN_LOW_MASK);
          opt_len  = '0;
          if (len_left == 0) finish_length();
          else rx_phase = PH_LENEXT;
        end else begin
          opt_len = {24'd0, b};
          finish_length();
        end
      end
      PH_LENEXT: begin
        opt_len  = {opt_len[23:0], b};
        len_left = len_left - 7'd1;
        if (len_left == 0) finish_length();
      end
      PH_VALUE: begin
        if (opt_tag == sid_tag) id_acc = {id_acc[23:0], b};
        opt_len = opt_len - 32'd1;
        if (opt_len == 0) begin
          if (opt_tag == sid_tag) search_ids(id_acc);
          else rx_phase = PH_TAG;
        end
      end
      default: ;
    endcase
  endfunction

  // Applies one accepted input transfer and queues the verdict it causes.
  function automatic void track_item(input stim_t it);
    verdict_t v;
    if (it.mode == MODE_ENTRY) begin
      stream_ids[it.entry_index] = it.entry_id;
      return;
    end
    if (it.first) begin
      reset_scan();
      rx_total = (it.pkt_len < MAX_PACKET_BYTES) ? it.pkt_len : MAX_PACKET_BYTES;
      if (it.data_byte != packet_code) begin
        verdict  = OUT_NOT_STAT;
        rx_phase = PH_DONE;
      end else begin
        rx_phase = PH_TAG;
      end
    end else begin
      if (rx_phase == PH_IDLE) return;
      if (rx_pos >= rx_total) close_option_list();
      else advance_option_parser(it.data_byte);
    end
    if (rx_pos < POS_MAX) rx_pos = rx_pos + 12'd1;
    if (!it.last) return;
    close_option_list();
    v.outcome  = verdict;
    v.found_id = (verdict == OUT_MATCH) ? hit_id : 32'hFFFF_FFFF;
    expected_verdicts.push_back(v);
    reset_scan();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, sink stalls and watchdog
  // ---------------------------------------------------------------------------

  // Compare each result transfer with the oldest expected verdict.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: outcome %0d, found_id %0d",
               m_axis_tdata[1:0], $signed(m_axis_tdata[33:2]));
        err_cnt++;
      end else begin
        head_v = expected_verdicts.pop_front();
        if (m_axis_tdata[1:0] !== head_v.outcome) begin
          $error("outcome: expected %0d, actual %0d", head_v.outcome, m_axis_tdata[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[33:2] !== head_v.found_id) begin
          $error("found_id: expected %0d, actual %0d",
                 $signed(head_v.found_id), $signed(m_axis_tdata[33:2]));
          err_cnt++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no transfer of any kind has happened for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic stim_t rand_stim();
    stim_t it;
    it.mode        = MODE_PACKET;
    it.data_byte   = 8'($urandom);
    it.first       = 1'($urandom);
    it.last        = 1'($urandom);
    it.pkt_len     = 12'($urandom_range(2048));
    it.entry_index = 4'($urandom);
    it.entry_id    = $urandom;
    return it;
  endfunction

  // Drives one input transfer and waits for it to be taken. Valid stays high
  // on return so that a following call can go on back to back.
  task automatic send_item(input stim_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.entry_id, it.entry_index, it.pkt_len, it.data_byte};
    s_axis_tuser  <= {it.first, it.mode};
    s_axis_tlast  <= it.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_item(it);
  endtask

  task automatic write_id(input logic [3:0] slot, input logic [31:0] id_val);
    stim_t it;
    it             = rand_stim();
    it.mode        = MODE_ENTRY;
    it.entry_index = slot;
    it.entry_id    = id_val;
    send_item(it);
    items_sent++;
  endtask

  // Sends the first n_send bytes of pkt_bytes; the last one is marked only
  // when close is set.
  task automatic send_packet(input int n_send, input bit close);
    stim_t it;
    for (int i = 0; i < n_send; i++) begin
      if (i > 0 && $urandom_range(99) < mix_pct) write_id(4'($urandom), $urandom);
      it           = rand_stim();
      it.data_byte = pkt_bytes[i];
      it.first     = (i == 0);
      it.last      = close && (i == n_send - 1);
      if (i == 0) it.pkt_len = pkt_len_field;
      send_item(it);
      items_sent++;
    end
  endtask

  task automatic stray_byte();
    stim_t it;
    it       = rand_stim();
    it.first = 1'b0;
    send_item(it);
  endtask

  // Stops the sender, waits for every expected verdict, then lets a table
  // search that gives no result run out.
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_STATUS_CODE: packet_code = val;
      CFG_END_TAG:     end_tag     = val;
      CFG_STREAM_TAG:  sid_tag     = val;
      CFG_ENTRY_COUNT: live_count  = val[4:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] code, input logic [7:0] etag,
                            input logic [7:0] stag, input logic [7:0] count);
    write_reg(CFG_STATUS_CODE, code);
    write_reg(CFG_END_TAG, etag);
    write_reg(CFG_STREAM_TAG, stag);
    write_reg(CFG_ENTRY_COUNT, count);
  endtask

  // ---------------------------------------------------------------------------
  // Packet generation
  // ---------------------------------------------------------------------------

  // Builds a mostly well formed status packet from the current configuration,
  // with stream id values often taken from the table.
  function automatic void build_packet();
    int          r;
    int          vlen;
    int          nlen;
    int          pl;
    logic [7:0]  t;
    logic [31:0] v;
    pkt_bytes.delete();
    pkt_bytes.push_back(($urandom_range(99) < 85) ? packet_code : 8'($urandom));
    repeat ($urandom_range(4)) begin
      r = $urandom_range(99);
      t = (r < 45) ? sid_tag : (r < 52) ? end_tag : 8'($urandom);
      pkt_bytes.push_back(t);
      vlen = (t == sid_tag) ? $urandom_range(6) : $urandom_range(8);
      r = $urandom_range(99);
      if (r < 70) begin
        pkt_bytes.push_back(8'(vlen));
      end else if (r < 92) begin
        // Extended form with leading zero bytes.
        nlen = $urandom_range(1, 4);
        pkt_bytes.push_back(LEN_EXT_FLAG | 8'(nlen));
        for (int k = nlen - 1; k >= 0; k--) pkt_bytes.push_back(8'(vlen >> (8 * k)));
      end else begin
        // Odd extended forms: empty, over 32 bits, or arbitrary length bytes.
        nlen = $urandom_range(0, 6);
        pkt_bytes.push_back(LEN_EXT_FLAG | 8'(nlen));
        repeat (nlen) pkt_bytes.push_back(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom));
      end
      v = ($urandom_range(1) == 0) ? stream_ids[$urandom_range(TBL_ENTRIES - 1)] : $urandom;
      for (int k = vlen - 1; k >= 0; k--) begin
        pkt_bytes.push_back((k < 4) ? 8'(v >> (8 * k)) : 8'($urandom));
      end
    end
    if ($urandom_range(1) == 0) pkt_bytes.push_back(end_tag);
    repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom));
    r  = $urandom_range(99);
    pl = pkt_bytes.size();
    if (r >= 95) pl = $urandom_range(2048);
    else if (r >= 85) pl = pl + $urandom_range(1, 4);
    else if (r >= 70) pl = pl - $urandom_range(1, 4);
    if (pl < 0) pl = 0;
    pkt_len_field = 12'(pl);
  endfunction

  // Mix of table writes, stray bytes, dropped packets and whole packets.
  task automatic run_traffic(input int n_items);
    int goal;
    int r;
    int loops;
    goal  = items_sent + n_items;
    loops = 0;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 6) begin
        stray_byte();
      end else if (r < 14) begin
        write_id(4'($urandom), $urandom);
      end else begin
        if (r < 24) begin
          build_packet();
          send_packet($urandom_range(1, pkt_bytes.size()), 1'b0);
        end
        build_packet();
        send_packet(pkt_bytes.size(), 1'b1);
      end
      loops++;
      if (loops % 40 == 0) settle_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    stim_t it;
    idle_pct  = 0;
    stall_pct = 0;
    mix_pct   = 0;
    set_config(8'hFF, 8'h00, 8'h12, 8'd4);
    write_id(4'd0, 32'h8000_0000);
    write_id(4'd1, 32'h7FFF_FFFF);
    write_id(4'd2, 32'h0000_0000);
    write_id(4'd3, 32'hFFFF_FFFF);
    // A byte with no packet open is dropped, even when marked last.
    it       = rand_stim();
    it.first = 1'b0;
    it.last  = 1'b1;
    send_item(it);
    // Single byte packet: no options.
    pkt_bytes = '{8'hFF};
    pkt_len_field = 12'd1;
    send_packet(pkt_bytes.size(), 1'b1);
    // Wrong packet type, with a zero declared length.
    pkt_bytes = '{8'h00, 8'h5A};
    pkt_len_field = 12'd0;
    send_packet(pkt_bytes.size(), 1'b1);
    // Stream id hit on the most negative id, declared length at the packet length limit.
    pkt_bytes = '{8'hFF, 8'h12, 8'h04, 8'h80, 8'h00, 8'h00, 8'h00};
    pkt_len_field = 12'd2048;
    send_packet(pkt_bytes.size(), 1'b1);
    // Packet cut short by a new first byte, then an empty stream id value.
    pkt_bytes = '{8'hFF, 8'h07};
    send_packet(pkt_bytes.size(), 1'b0);
    pkt_bytes = '{8'hFF, 8'h12, 8'h00};
    pkt_len_field = 12'd4;
    send_packet(pkt_bytes.size(), 1'b1);
    // Packet ends inside the extended length bytes.
    pkt_bytes = '{8'hFF, 8'h07, 8'h82, 8'h00};
    pkt_len_field = 12'd2048;
    send_packet(pkt_bytes.size(), 1'b1);
    // Option value reaches the declared packet end.
    pkt_bytes = '{8'hFF, 8'h07, 8'h01, 8'h09};
    pkt_len_field = 12'd4;
    send_packet(pkt_bytes.size(), 1'b1);
  endtask

  task automatic test_back_to_back();
    settle_results();
    for (int i = 0; i < TBL_ENTRIES; i++) write_id(4'(i), $urandom);
    settle_results();
    set_config(8'h00, 8'hFF, 8'h12, 8'd16);
    idle_pct  = 0;
    stall_pct = 0;
    mix_pct   = 5;
    run_traffic(170);
  endtask

  task automatic test_sender_gaps();
    settle_results();
    set_config(8'hA5, 8'h00, 8'hFF, 8'd0);
    idle_pct  = 86;
    stall_pct = 0;
    run_traffic(170);
  endtask

  // The end tag and the stream id tag are the same here.
  task automatic test_sink_stalls();
    settle_results();
    set_config(8'h5A, 8'h33, 8'h33, 8'd9);
    idle_pct  = 0;
    stall_pct = 86;
    run_traffic(170);
  endtask

  task automatic test_mixed_gaps();
    settle_results();
    set_config(8'hFF, 8'h01, 8'h80, 8'd16);
    idle_pct  = 13;
    stall_pct = 13;
    run_traffic(170);
  endtask

  initial begin
    reset_scan();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_sink_stalls();
    test_mixed_gaps();
    settle_results();
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* tlv_stream_id_matcher.f */
hw/rtl/tlvsim_pkg.sv
hw/rtl/tlvsim_ram.sv
hw/rtl/tlv_stream_id_matcher.sv
hw/rtl/tlvsim_checker.sv
tb/tb.sv
